// File: rtl/core/mcd_pkg.sv
// Package for the maze carver: request and result payload types, mode, kind and
// direction codes, default grid size and the direction shuffle.
// No dependencies.
package mcd_pkg;

	// Fields of one request.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rand_bits;
		logic [4:0] read_x;
		logic [4:0] read_y;
	} cmd_t;

	// Fields of one result.
	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic       is_wall;
		logic       last;
	} res_t;

	localparam logic [1:0] MODE_RESTART = 2'd0;
	localparam logic [1:0] MODE_ADVANCE = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	localparam logic [1:0] KIND_CARVE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	localparam int GRID_W_DEF = 32;
	localparam int GRID_H_DEF = 32;

	// The stack holds 256 frames; its depth counter needs one more bit.
	localparam int STACK_AW = 8;
	localparam int DEPTH_W  = STACK_AW + 1;

	// Start from north, east, south, west and swap position i with the
	// position named by bits 2i+1..2i of the random byte.
	function automatic logic [3:0][1:0] shuffle_dirs(input logic [7:0] rnd);
		logic [3:0][1:0] d;
		logic [1:0]      r;
		logic [1:0]      t;
		d = {DIR_W, DIR_S, DIR_E, DIR_N};
		for (int i = 0; i < 4; i++) begin
			r    = rnd[2*i +: 2];
			t    = d[r];
			d[r] = d[i];
			d[i] = t;
		end
		return d;
	endfunction

endpackage

// File: rtl/core/maze_carver_dfs.sv
// Maze carver top level: depth-first maze generation over a one-bit cell map
// with an explicit frame stack. Depends on mcd_pkg.
// Cell map and frame stack are synchronous memories inside this module.
//
// Request paths: a read looks up the cell map unless it lies outside the grid; an advance
// on an empty stack answers done, else it pops, stops at a target off the grid, open or
// with the stack full, or carves two cells. A full output register holds these steps.
// One request at a time; the next is taken in idle even while a result still waits.
// A restart runs the clearing sweep, one cell per cycle through the single write port.
// After reset the same sweep runs before the first request is taken.
module maze_carver_dfs #(
	parameter int GRID_W = mcd_pkg::GRID_W_DEF,
	parameter int GRID_H = mcd_pkg::GRID_H_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mcd_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output mcd_pkg::res_t  res
);

	localparam int XW      = $clog2(GRID_W);
	localparam int YW      = $clog2(GRID_H);
	localparam int MAP_N   = GRID_W * GRID_H;
	localparam int MAP_AW  = $clog2(MAP_N);
	localparam int STACK_N = 2 ** mcd_pkg::STACK_AW;

	// One search frame: cell, its shuffled directions and the next one to try.
	typedef struct packed {
		logic [XW-1:0]   x;
		logic [YW-1:0]   y;
		logic [3:0][1:0] dir;
		logic [2:0]      nxt;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_CLEAR     = 9'b000000001,
		ST_INIT      = 9'b000000010,
		ST_IDLE      = 9'b000000100,
		ST_RD_TOP    = 9'b000001000,
		ST_RD_TGT    = 9'b000010000,
		ST_CARVE_MID = 9'b000100000,
		ST_CARVE_TGT = 9'b001000000,
		ST_RD_CELL   = 9'b010000000,
		ST_EMIT      = 9'b100000000
	} state_t;

	// Row-major cell address; the multiply is by a constant.
	function automatic logic [MAP_AW-1:0] cell_idx(input logic [XW-1:0] x,
	                                               input logic [YW-1:0] y);
		logic [31:0] t;
		t = 32'(y) * 32'(GRID_W) + 32'(x);
		return MAP_AW'(t);
	endfunction

	state_t                       state_q, state_d;
	logic [mcd_pkg::DEPTH_W-1:0]  depth_q, depth_d;
	logic [MAP_AW-1:0]            clr_q, clr_d;
	logic                         restart_q, restart_d;
	logic                         res_valid_q;
	mcd_pkg::res_t                res_q;

	// Request payload kept for the steps that follow acceptance.
	logic [7:0]    rnd_q;
	mcd_pkg::res_t pend_q;
	logic [XW-1:0] tx_q, mx_q;
	logic [YW-1:0] ty_q, my_q;

	// Cell map: 1 means wall.
	logic               map_mem [MAP_N];
	logic               map_we, map_wd, map_rdata;
	logic [MAP_AW-1:0]  map_wa, map_ra;

	// Frame stack.
	logic [FRAME_W-1:0]          stk_mem [STACK_N];
	logic                        stk_we;
	logic [mcd_pkg::STACK_AW-1:0] stk_wa, stk_ra;
	logic [FRAME_W-1:0]          stk_wd, stk_rdata;

	logic          accept, res_free, res_load;
	mcd_pkg::res_t res_load_data;

	logic                        cmd_in_grid;
	logic [MAP_AW-1:0]           cmd_idx;
	logic [mcd_pkg::DEPTH_W-1:0] depth_m1;
	frame_t                      top, top_wb, new_frame;
	logic [1:0]                  dir_cur;
	logic [XW+1:0]               xw;
	logic [YW+1:0]               yw;
	logic                        tgt_ok;
	logic [XW-1:0]               tx_c, mx_c;
	logic [YW-1:0]               ty_c, my_c;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	// The output register can take a new result when empty or being emptied.
	assign res_free  = !res_valid_q || res_ready;

	// A read outside the grid answers wall without touching the map.
	assign cmd_in_grid = (9'(cmd.read_x) < 9'(GRID_W)) && (9'(cmd.read_y) < 9'(GRID_H));
	assign cmd_idx     = cell_idx(XW'(cmd.read_x), YW'(cmd.read_y));

	// The top frame sits one below the depth counter.
	assign depth_m1 = depth_q - mcd_pkg::DEPTH_W'(1);
	assign stk_ra   = depth_m1[mcd_pkg::STACK_AW-1:0];
	assign top      = frame_t'(stk_rdata);
	assign dir_cur  = top.dir[top.nxt[1:0]];

	always_comb begin
		top_wb     = top;
		top_wb.nxt = top.nxt + 3'd1;
	end

	// Frame for the cell being pushed: the target of a carve, or (1,1) on restart.
	always_comb begin
		new_frame.x   = (state_q == ST_INIT) ? XW'(1) : tx_q;
		new_frame.y   = (state_q == ST_INIT) ? YW'(1) : ty_q;
		new_frame.dir = mcd_pkg::shuffle_dirs(rnd_q);
		new_frame.nxt = 3'd0;
	end

	// Target two steps away and the cell between, with the bounds check.
	assign xw = (XW+2)'(top.x);
	assign yw = (YW+2)'(top.y);

	always_comb begin
		tx_c = top.x;
		mx_c = top.x;
		ty_c = top.y;
		my_c = top.y;
		unique case (dir_cur)
			mcd_pkg::DIR_N: begin
				tgt_ok = (yw >= (YW+2)'(2));
				ty_c   = YW'(yw - (YW+2)'(2));
				my_c   = YW'(yw - (YW+2)'(1));
			end
			mcd_pkg::DIR_E: begin
				tgt_ok = ((xw + (XW+2)'(2)) < (XW+2)'(GRID_W));
				tx_c   = XW'(xw + (XW+2)'(2));
				mx_c   = XW'(xw + (XW+2)'(1));
			end
			mcd_pkg::DIR_S: begin
				tgt_ok = ((yw + (YW+2)'(2)) < (YW+2)'(GRID_H));
				ty_c   = YW'(yw + (YW+2)'(2));
				my_c   = YW'(yw + (YW+2)'(1));
			end
			mcd_pkg::DIR_W: begin
				tgt_ok = (xw >= (XW+2)'(2));
				tx_c   = XW'(xw - (XW+2)'(2));
				mx_c   = XW'(xw - (XW+2)'(1));
			end
		endcase
	end

	// Sequencer: next state, memory ports and result loads.
	always_comb begin
		state_d       = state_q;
		depth_d       = depth_q;
		clr_d         = clr_q;
		restart_d     = restart_q;
		res_load      = 1'b0;
		res_load_data = pend_q;
		map_we        = 1'b0;
		map_wa        = clr_q;
		map_wd        = 1'b1;
		map_ra        = cmd_idx;
		stk_we        = 1'b0;
		stk_wa        = stk_ra;
		stk_wd        = top_wb;
		unique case (state_q)
			ST_CLEAR: begin
				// Sweep every cell back to wall.
				map_we = 1'b1;
				clr_d  = clr_q + MAP_AW'(1);
				if (clr_q == MAP_AW'(MAP_N - 1)) begin
					clr_d     = '0;
					restart_d = 1'b0;
					state_d   = restart_q ? ST_INIT : ST_IDLE;
				end
			end
			ST_INIT: begin
				// Open (1,1) and make it the only frame. The writes repeat
				// harmlessly while the result slot is busy.
				map_we = 1'b1;
				map_wa = cell_idx(XW'(1), YW'(1));
				map_wd = 1'b0;
				stk_we = 1'b1;
				stk_wa = '0;
				stk_wd = new_frame;
				depth_d = mcd_pkg::DEPTH_W'(1);
				if (res_free) begin
					res_load      = 1'b1;
					res_load_data = '{kind: mcd_pkg::KIND_CARVE, cell_x: 5'd1, cell_y: 5'd1,
					                  is_wall: 1'b0, last: 1'b1};
					state_d       = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.mode)
						mcd_pkg::MODE_RESTART: begin
							restart_d = 1'b1;
							state_d   = ST_CLEAR;
						end
						mcd_pkg::MODE_ADVANCE: begin
							state_d = (depth_q == '0) ? ST_EMIT : ST_RD_TOP;
						end
						mcd_pkg::MODE_READ: begin
							state_d = cmd_in_grid ? ST_RD_CELL : ST_EMIT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD_TOP: begin
				if (top.nxt[2]) begin
					// All four directions tried: pop.
					depth_d = depth_m1;
					state_d = ST_IDLE;
				end else begin
					// Count the direction as done and look at its target cell.
					stk_we  = 1'b1;
					map_ra  = cell_idx(tx_c, ty_c);
					state_d = tgt_ok ? ST_RD_TGT : ST_IDLE;
				end
			end
			ST_RD_TGT: begin
				// Carve only into a wall cell, and only if a frame can be pushed.
				state_d = (map_rdata && !depth_q[mcd_pkg::DEPTH_W-1]) ? ST_CARVE_MID : ST_IDLE;
			end
			ST_CARVE_MID: begin
				if (res_free) begin
					map_we        = 1'b1;
					map_wa        = cell_idx(mx_q, my_q);
					map_wd        = 1'b0;
					res_load      = 1'b1;
					res_load_data = '{kind: mcd_pkg::KIND_CARVE, cell_x: 5'(mx_q),
					                  cell_y: 5'(my_q), is_wall: 1'b0, last: 1'b0};
					state_d       = ST_CARVE_TGT;
				end
			end
			ST_CARVE_TGT: begin
				if (res_free) begin
					map_we        = 1'b1;
					map_wa        = cell_idx(tx_q, ty_q);
					map_wd        = 1'b0;
					stk_we        = 1'b1;
					stk_wa        = depth_q[mcd_pkg::STACK_AW-1:0];
					stk_wd        = new_frame;
					depth_d       = depth_q + mcd_pkg::DEPTH_W'(1);
					res_load      = 1'b1;
					res_load_data = '{kind: mcd_pkg::KIND_CARVE, cell_x: 5'(tx_q),
					                  cell_y: 5'(ty_q), is_wall: 1'b0, last: 1'b1};
					state_d       = ST_IDLE;
				end
			end
			ST_RD_CELL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			depth_q     <= '0;
			clr_q       <= '0;
			restart_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			clr_q     <= clr_d;
			restart_q <= restart_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rnd_q <= cmd.rand_bits;
			if (cmd.mode == mcd_pkg::MODE_ADVANCE) begin
				pend_q <= '{kind: mcd_pkg::KIND_DONE, cell_x: 5'd0, cell_y: 5'd0,
				           is_wall: 1'b0, last: 1'b1};
			end else begin
				pend_q <= '{kind: mcd_pkg::KIND_READ, cell_x: cmd.read_x,
				           cell_y: cmd.read_y, is_wall: 1'b1, last: 1'b1};
			end
		end
		if (state_q == ST_RD_CELL) begin
			pend_q.is_wall <= map_rdata;
		end
		if (state_q == ST_RD_TOP) begin
			tx_q <= tx_c;
			ty_q <= ty_c;
			mx_q <= mx_c;
			my_q <= my_c;
		end
		if (res_load) begin
			res_q <= res_load_data;
		end
	end

	// Cell map memory.
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rdata <= map_mem[map_ra];
	end

	// Frame stack memory.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rdata <= stk_mem[stk_ra];
	end

	// The stack never holds more frames than it has entries.
	a_depth_cap: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= mcd_pkg::DEPTH_W'(STACK_N))
		else $error("stack depth beyond capacity");

	// The first cell of a carve pair is only shown while the second is pending.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.last) |-> (state_q == ST_CARVE_TGT))
		else $error("carve result without its partner pending");

	// No memory write happens in the cycle a request is taken.
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!map_we && !stk_we))
		else $error("memory write while taking a request");

	// A finished carve pushes exactly one frame.
	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CARVE_TGT && res_free) |=>
			(depth_q == $past(depth_q) + mcd_pkg::DEPTH_W'(1)))
		else $error("carve did not push one frame");

endmodule
